/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Implication checked in the same cycle outside of reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

/* rtl/ivc_pkg.sv */
// ----------------------------------------------------------------------------
// ivc_pkg
// Types and fixed constants shared by the window convolution modules.
// ----------------------------------------------------------------------------
package ivc_pkg;

    // Field widths fixed by the register and stream formats.
    localparam int PIX_W      = 8;
    localparam int COEF_DIM   = 5;
    localparam int COEF_W     = 12;
    localparam int COEF_ROW_W = COEF_DIM * COEF_W;
    localparam int KS_W       = 3;
    localparam int FRAME_W    = 11;
    localparam int POS_W      = 10;
    localparam int VALUE_W    = 25;
    localparam int PROD_W     = 21;
    localparam int ROW_SUM_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_ROW_W;

    // Request queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_SIZE,
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT,
        CFG_COEF_ROW0,
        CFG_COEF_ROW1,
        CFG_COEF_ROW2,
        CFG_COEF_ROW3,
        CFG_COEF_ROW4
    } t_cfg_idx;

    // Window in kernel order: [row][column] of pixels.
    typedef logic [COEF_DIM-1:0][COEF_DIM-1:0][PIX_W-1:0] t_window;

    // Coefficient rows as written through the configuration port.
    typedef logic [COEF_DIM-1:0][COEF_ROW_W-1:0] t_coef_rows;

    // Frame geometry registers as seen by the front.
    typedef struct packed {
        logic [KS_W-1:0]    kernel_size;
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
    } t_geom;

    // One filter request handed from the front to the back.
    typedef struct packed {
        t_window          win;
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_col;
        logic             last;
    } t_job;

endpackage

/* rtl/ivc_ram.sv */
// ----------------------------------------------------------------------------
// ivc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ivc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ivc_front.sv */
// ----------------------------------------------------------------------------
// ivc_front
// Raster tracking, line stores and window assembly; issues filter requests.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ivc_front import ivc_pkg::*; #(
    parameter int MAX_KERNEL = 5,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_geom              i_geom,
    input  logic               i_pixel_valid,
    output logic               o_pixel_ready,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic [Q_CNT_W-1:0] i_q_count,
    output logic               o_push,
    output t_job               o_job
);

    localparam int KMAX = (MAX_KERNEL < COEF_DIM) ? MAX_KERNEL : COEF_DIM;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > FRAME_W) ? WW : FRAME_W;
    localparam int RH   = $clog2(MAX_HEIGHT);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CMPH = (HW > FRAME_W) ? HW : FRAME_W;
    localparam int SW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int SPW  = SW + 1;

    // Raster position of the next pixel and its line store slot.
    logic [CW-1:0] r_col, n_col, col0;
    logic [RH-1:0] r_row, n_row, row0;
    logic [SW-1:0] r_slot, n_slot, slot0;

    // Effective geometry.
    logic [KS_W-1:0] k, half_k, d_k;
    logic            even_k;
    logic [WW-1:0]   w, col_inc;
    logic [HW-1:0]   h, row_inc;

    logic             accept, wrap, emit, last;
    logic [POS_W-1:0] center_row, center_col;
    logic [Q_CNT_W:0] credit_used;

    // Second stage: line store data is valid here.
    logic             r_s1_valid, r_s1_emit;
    logic [PIX_W-1:0] r_s1_pixel;
    logic [SW-1:0]    r_s1_slot;
    logic [KS_W-1:0]  r_s1_k;
    logic [POS_W-1:0] r_s1_row, r_s1_col;
    logic             r_s1_last;

    logic [PIX_W-1:0] ram_q [MAX_KERNEL];
    logic [SW-1:0]    src_slot [COEF_DIM];
    logic [PIX_W-1:0] col_px [COEF_DIM];
    t_window          r_win, n_win;
    t_window          job_win;

    // Clamp the configured geometry into the supported range.
    always_comb begin
        if (i_geom.kernel_size == '0) begin
            k = KS_W'(1);
        end else if (i_geom.kernel_size > KS_W'(KMAX)) begin
            k = KS_W'(KMAX);
        end else begin
            k = i_geom.kernel_size;
        end

        if (i_geom.frame_width == '0) begin
            w = WW'(1);
        end else if (CMPW'(i_geom.frame_width) > CMPW'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(i_geom.frame_width);
        end

        if (i_geom.frame_height == '0) begin
            h = HW'(1);
        end else if (CMPH'(i_geom.frame_height) > CMPH'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(i_geom.frame_height);
        end
    end

    assign half_k = k >> 1;
    assign even_k = ~k[0];
    assign d_k    = k - KS_W'(1) - half_k;

    // A position beyond the frame restarts the frame at the origin.
    assign wrap  = (WW'(r_col) >= w) || (HW'(r_row) >= h);
    assign col0  = wrap ? '0 : r_col;
    assign row0  = wrap ? '0 : r_row;
    assign slot0 = wrap ? '0 : r_slot;

    // Hold off new pixels until the queue has room for every request in flight.
    assign credit_used   = (Q_CNT_W + 1)'(i_q_count) + (Q_CNT_W + 1)'(r_s1_valid && r_s1_emit);
    assign o_pixel_ready = i_rst_n && (credit_used < (Q_CNT_W + 1)'(Q_DEPTH));
    assign accept        = i_pixel_valid && o_pixel_ready;

    // Classify the pixel: does it complete the window of an interior center?
    assign emit = (WW'(col0) >= WW'(k - KS_W'(1)))
               && (HW'(row0) >= HW'(k - KS_W'(1)))
               && (WW'(col0) + WW'(even_k) < w)
               && (HW'(row0) + HW'(even_k) < h);
    assign last = (WW'(col0) + WW'(even_k) == w - WW'(1))
               && (HW'(row0) + HW'(even_k) == h - HW'(1));
    assign center_row = POS_W'(row0 - RH'(d_k));
    assign center_col = POS_W'(col0 - CW'(d_k));

    // Advance the raster position.
    always_comb begin
        col_inc = WW'(col0) + WW'(1);
        row_inc = HW'(row0) + HW'(1);
        n_col   = col0;
        n_row   = row0;
        n_slot  = slot0;
        if (col_inc >= w) begin
            n_col = '0;
            if (row_inc >= h) begin
                n_row  = '0;
                n_slot = '0;
            end else begin
                n_row  = row_inc[RH-1:0];
                n_slot = (slot0 == SW'(MAX_KERNEL - 1)) ? '0 : slot0 + SW'(1);
            end
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_slot     <= '0;
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
        end else begin
            if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_slot <= n_slot;
            end
            r_s1_valid <= accept;
            r_s1_emit  <= accept && emit;
        end
    end

    // Payload that travels with the pixel into the second stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel <= i_pixel;
            r_s1_slot  <= slot0;
            r_s1_k     <= k;
            r_s1_row   <= center_row;
            r_s1_col   <= center_col;
            r_s1_last  <= last;
        end
    end

    // One line store per slot; every slot is read at the current column.
    for (genvar s = 0; s < MAX_KERNEL; s++) begin : g_line
        ivc_ram #(
            .WIDTH(PIX_W),
            .DEPTH(MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (accept && (slot0 == SW'(s))),
            .i_waddr (col0),
            .i_wdata (i_pixel),
            .i_raddr (col0),
            .o_rdata (ram_q[s])
        );
    end

    // Slot that holds window row a: the current row minus (COEF_DIM - 1 - a),
    // modulo the slots. The window always spans the full set of rows.
    always_comb begin
        logic [SPW-1:0] off;
        logic [SPW-1:0] tmp;
        for (int a = 0; a < COEF_DIM; a++) begin
            off = SPW'(COEF_DIM - 1 - a);
            if (SPW'(r_s1_slot) >= off) begin
                tmp = SPW'(r_s1_slot) - off;
            end else begin
                tmp = SPW'(r_s1_slot) + SPW'(MAX_KERNEL) - off;
            end
            src_slot[a] = tmp[SW-1:0];
        end
    end

    // Assemble the new window column; the bottom row is the incoming pixel.
    always_comb begin
        for (int a = 0; a < COEF_DIM; a++) begin
            col_px[a] = '0;
            if (a == COEF_DIM - 1) begin
                col_px[a] = r_s1_pixel;
            end else if (COEF_DIM - 1 - a < MAX_KERNEL) begin
                col_px[a] = ram_q[src_slot[a]];
            end
        end
    end

    // Shift the full window left; the newest column lands in the last column.
    always_comb begin
        for (int a = 0; a < COEF_DIM; a++) begin
            n_win[a] = {col_px[a], r_win[a][COEF_DIM-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // Take the bottom-right k x k corner as the kernel window; unused taps are zero.
    always_comb begin
        logic [KS_W-1:0] base;
        base = KS_W'(COEF_DIM) - r_s1_k;
        for (int a = 0; a < COEF_DIM; a++) begin
            for (int b = 0; b < COEF_DIM; b++) begin
                job_win[a][b] = '0;
                if ((KS_W'(a) < r_s1_k) && (KS_W'(b) < r_s1_k)) begin
                    job_win[a][b] = n_win[base + KS_W'(a)][base + KS_W'(b)];
                end
            end
        end
    end

    // Request toward the back.
    assign o_push           = r_s1_valid && r_s1_emit;
    assign o_job.win        = job_win;
    assign o_job.center_row = r_s1_row;
    assign o_job.center_col = r_s1_col;
    assign o_job.last       = r_s1_last;

    // The slot always names one of the line stores.
    `ASSERT_ALWAYS(a_slot_range, i_clk, i_rst_n, SPW'(r_slot) < SPW'(MAX_KERNEL), "line store slot out of range")
    // The first row of a frame always uses the first slot.
    `ASSERT_IMPLIES(a_slot_first_row, i_clk, i_rst_n, r_row == '0, r_slot == '0, "slot not aligned to frame start")

endmodule

/* rtl/ivc_queue.sv */
// ----------------------------------------------------------------------------
// ivc_queue
// Short request queue that decouples the front from the arithmetic back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ivc_queue import ivc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_job               i_job,
    input  logic               i_pop,
    output logic               o_valid,
    output t_job               o_head,
    output logic [Q_CNT_W-1:0] o_count
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    // Request storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

    `ASSERT_IMPLIES(a_q_no_overflow, i_clk, i_rst_n, i_push, (r_count < Q_CNT_W'(Q_DEPTH)) || i_pop, "request queue overflow")
    `ASSERT_IMPLIES(a_q_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "request queue underflow")
    `ASSERT_IMPLIES(a_q_empty_ptrs, i_clk, i_rst_n, r_count == '0, r_wptr == r_rptr, "empty queue with split pointers")

endmodule

/* rtl/ivc_back.sv */
// ----------------------------------------------------------------------------
// ivc_back
// Multiply-accumulate pipeline: products, row sums, total and result register.
// ----------------------------------------------------------------------------
module ivc_back import ivc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_coef_rows                i_coef,
    input  logic                      i_q_valid,
    input  t_job                      i_q_head,
    output logic                      o_q_pop,
    output logic                      o_result_valid,
    input  logic                      i_result_ready,
    output logic signed [VALUE_W-1:0] o_filtered_value,
    output logic [POS_W-1:0]          o_center_row,
    output logic [POS_W-1:0]          o_center_col,
    output logic                      o_last_of_frame
);

    logic en;

    logic signed [COEF_W-1:0]    coef_s [COEF_DIM][COEF_DIM];
    logic signed [PIX_W:0]       pix_s  [COEF_DIM][COEF_DIM];
    logic signed [ROW_SUM_W-1:0] row_sum [COEF_DIM];
    logic signed [VALUE_W-1:0]   total;

    // Product stage.
    logic                      r_p_valid;
    logic signed [PROD_W-1:0]  r_p_prod [COEF_DIM][COEF_DIM];
    logic [POS_W-1:0]          r_p_row, r_p_col;
    logic                      r_p_last;

    // Row sum stage.
    logic                        r_r_valid;
    logic signed [ROW_SUM_W-1:0] r_r_sum [COEF_DIM];
    logic [POS_W-1:0]            r_r_row, r_r_col;
    logic                        r_r_last;

    // Result register.
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [POS_W-1:0]          r_out_row, r_out_col;
    logic                      r_out_last;

    // The whole pipeline moves unless a held result blocks it.
    assign en      = !r_out_valid || i_result_ready;
    assign o_q_pop = en && i_q_valid;

    // Signed operands: Q4.8 coefficient and zero-extended pixel.
    always_comb begin
        for (int a = 0; a < COEF_DIM; a++) begin
            for (int b = 0; b < COEF_DIM; b++) begin
                coef_s[a][b] = i_coef[a][COEF_W * b +: COEF_W];
                pix_s[a][b]  = {1'b0, i_q_head.win[a][b]};
            end
        end
    end

    // Sum of each kernel row.
    always_comb begin
        for (int a = 0; a < COEF_DIM; a++) begin
            row_sum[a] = '0;
            for (int b = 0; b < COEF_DIM; b++) begin
                row_sum[a] = row_sum[a] + ROW_SUM_W'(r_p_prod[a][b]);
            end
        end
    end

    // Sum of the row sums.
    always_comb begin
        total = '0;
        for (int a = 0; a < COEF_DIM; a++) begin
            total = total + VALUE_W'(r_r_sum[a]);
        end
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_r_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_p_valid   <= o_q_pop;
            r_r_valid   <= r_p_valid;
            r_out_valid <= r_r_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < COEF_DIM; a++) begin
                for (int b = 0; b < COEF_DIM; b++) begin
                    r_p_prod[a][b] <= coef_s[a][b] * pix_s[a][b];
                end
                r_r_sum[a] <= row_sum[a];
            end
            r_p_row     <= i_q_head.center_row;
            r_p_col     <= i_q_head.center_col;
            r_p_last    <= i_q_head.last;
            r_r_row     <= r_p_row;
            r_r_col     <= r_p_col;
            r_r_last    <= r_p_last;
            r_out_value <= total;
            r_out_row   <= r_r_row;
            r_out_col   <= r_r_col;
            r_out_last  <= r_r_last;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_filtered_value = r_out_value;
    assign o_center_row     = r_out_row;
    assign o_center_col     = r_out_col;
    assign o_last_of_frame  = r_out_last;

endmodule

/* rtl/image_window_convolution.sv */
// ----------------------------------------------------------------------------
// image_window_convolution
// Streaming 2-D sliding-window correlation over 8-bit raster pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the i_pixel_valid / o_pixel_ready channel,
// one request per cycle. For each pixel that completes the window of an
// interior center, one result leaves on o_result_valid / i_result_ready with
// the weighted sum in units of 1/256, the center position and an end-of-frame
// flag. Border centers produce nothing.
// Results pass line store, window shift, queue, product, row sum, total.
// Throughput: one pixel per cycle, set by the single write and read port of
// each line store; the multipliers and adders are fully pipelined.
// A stalled receiver freezes the arithmetic pipeline; a four-entry request
// queue absorbs what is in flight and then o_pixel_ready drops.
// Registers are written through i_cfg_wr_en / i_cfg_index / i_cfg_data
// while the block is idle; the user keeps to that, the block does not
// enforce it. Reset restores a 3x3 kernel, a 1024x1024 frame, zero
// coefficients and the frame origin; the line stores are not cleared.
// ----------------------------------------------------------------------------
module image_window_convolution import ivc_pkg::*; #(
    parameter int MAX_KERNEL = 5,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    // Pixel input channel
    input  logic                      i_pixel_valid,
    output logic                      o_pixel_ready,
    input  logic [PIX_W-1:0]          i_pixel,
    // Result output channel
    output logic                      o_result_valid,
    input  logic                      i_result_ready,
    output logic signed [VALUE_W-1:0] o_filtered_value,
    output logic [POS_W-1:0]          o_center_row,
    output logic [POS_W-1:0]          o_center_col,
    output logic                      o_last_of_frame
);

    logic [KS_W-1:0]    r_kernel_size;
    logic [FRAME_W-1:0] r_frame_width;
    logic [FRAME_W-1:0] r_frame_height;
    t_coef_rows         r_coef;

    t_geom              geom;
    logic               push;
    t_job               push_job;
    logic               q_valid;
    t_job               q_head;
    logic               q_pop;
    logic [Q_CNT_W-1:0] q_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_size  <= KS_W'(3);
            r_frame_width  <= FRAME_W'(1024);
            r_frame_height <= FRAME_W'(1024);
            r_coef         <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KERNEL_SIZE: begin
                    r_kernel_size <= i_cfg_data[KS_W-1:0];
                end
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[FRAME_W-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[FRAME_W-1:0];
                end
                CFG_COEF_ROW0: begin
                    r_coef[0] <= i_cfg_data[COEF_ROW_W-1:0];
                end
                CFG_COEF_ROW1: begin
                    r_coef[1] <= i_cfg_data[COEF_ROW_W-1:0];
                end
                CFG_COEF_ROW2: begin
                    r_coef[2] <= i_cfg_data[COEF_ROW_W-1:0];
                end
                CFG_COEF_ROW3: begin
                    r_coef[3] <= i_cfg_data[COEF_ROW_W-1:0];
                end
                CFG_COEF_ROW4: begin
                    r_coef[4] <= i_cfg_data[COEF_ROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign geom.kernel_size  = r_kernel_size;
    assign geom.frame_width  = r_frame_width;
    assign geom.frame_height = r_frame_height;

    // Front: raster tracking, line stores and window assembly.
    ivc_front #(
        .MAX_KERNEL(MAX_KERNEL),
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (geom),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel       (i_pixel),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_job         (push_job)
    );

    // Request queue between front and back.
    ivc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_count (q_count)
    );

    // Back: multiply-accumulate pipeline and result register.
    ivc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_coef           (r_coef),
        .i_q_valid        (q_valid),
        .i_q_head         (q_head),
        .o_q_pop          (q_pop),
        .o_result_valid   (o_result_valid),
        .i_result_ready   (i_result_ready),
        .o_filtered_value (o_filtered_value),
        .o_center_row     (o_center_row),
        .o_center_col     (o_center_col),
        .o_last_of_frame  (o_last_of_frame)
    );

endmodule
